// File: hdl/lrc_pkg.sv
// shared constants and types for the lru lookup table cache directory
`default_nettype none
package lrc_pkg;

  localparam int unsigned MAX_ENTRIES = 8;
  localparam int unsigned KEY_BITS    = 64;

  localparam int unsigned SLOT_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LOOKUP
  } lrc_state_e;

endpackage
`default_nettype wire

// File: hdl/lrc_cell.sv
// one directory cell: holds a tag and slot, compares, hands contents to the next cell
`default_nettype none
module lrc_cell
  import lrc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                shift_en_i,
  input  wire logic [KEY_BITS-1:0] tag_i,
  input  wire logic [SLOT_W-1:0]   slot_i,
  input  wire logic [KEY_BITS-1:0] key_i,
  output logic      [KEY_BITS-1:0] tag_o,
  output logic      [SLOT_W-1:0]   slot_o,
  output logic                     match_o
);

  logic [KEY_BITS-1:0] tag_q;
  logic [SLOT_W-1:0]   slot_q;

  // payload only, validity is tracked by the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q  <= '0;
      slot_q <= '0;
    end else if (shift_en_i) begin
      tag_q  <= tag_i;
      slot_q <= slot_i;
    end
  end

  assign tag_o   = tag_q;
  assign slot_o  = slot_q;
  assign match_o = (tag_q == key_i);

endmodule
`default_nettype wire

// File: hdl/lru_lookup_table_cache.sv
// Fully associative directory with most-recently-used order.
// Input channel s_axis: tdata carries the 64-bit key tag, tuser the fill_ok
// flag. An item is taken when tvalid and tready are both high.
// Output channel m_axis: one result item per request, with hit, ok, slot,
// evicted, the hit and miss counters and the number of valid entries.
// The entries sit in a row of cells, most recent first. The accept cycle
// registers the key; the lookup state then compares the key against every
// cell, picks the frontmost match and, on a hit or a fill, shifts the row
// by one cell up to that position while the new front entry goes into cell 0.
// The result is registered, and a new request can be taken in the cycle in
// which it appears; no new request is taken while a lookup is pending.
// If the receiver stalls, the result waits in the output register; a new
// request is still taken, but its lookup holds until the register frees.
// Reset (rst_ni low, asynchronous) empties the directory and clears both
// counters; no clearing pass is needed.
`default_nettype none
module lru_lookup_table_cache
  import lrc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // key_tag[63:0]
  input  wire logic [0:0]            s_axis_tuser,  // fill_ok[0]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // hit[0], ok[1], slot[4:2], evicted[5], hit_count[37:6],
  // miss_count[69:38], entries_used[73:70], zero[79:74]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata
);

  lrc_state_e state_q, state_d;

  logic [KEY_BITS-1:0] key_q;
  logic                fill_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [31:0]         hits_q, misses_q;

  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;

  logic in_take, do_update;

  logic [KEY_BITS-1:0] cell_tag  [MAX_ENTRIES];
  logic [SLOT_W-1:0]   cell_slot [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_match, cell_valid, shift_en;

  logic                found;
  logic [SLOT_W-1:0]   hit_pos, hit_slot, pos;
  logic [SLOT_W-1:0]   front_slot;
  logic                full, fill_now, evict;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_LOOKUP;
      ST_LOOKUP: if (do_update) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    do_update     = 1'b0;
    case (state_q)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_LOOKUP: do_update = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_take = s_axis_tvalid && s_axis_tready;

  // cell row
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [KEY_BITS-1:0] up_tag;
    logic [SLOT_W-1:0]   up_slot;
    if (i == 0) begin : g_front
      assign up_tag  = key_q;
      assign up_slot = front_slot;
    end else begin : g_next
      assign up_tag  = cell_tag[i-1];
      assign up_slot = cell_slot[i-1];
    end

    assign cell_valid[i] = (CNT_W'(i) < count_q);
    assign shift_en[i]   = do_update && (fill_now || found) && (SLOT_W'(i) <= pos);

    lrc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en[i]),
      .tag_i      (up_tag),
      .slot_i     (up_slot),
      .key_i      (key_q),
      .tag_o      (cell_tag[i]),
      .slot_o     (cell_slot[i]),
      .match_o    (cell_match[i])
    );
  end

  // frontmost valid match
  always_comb begin
    found    = 1'b0;
    hit_pos  = '0;
    hit_slot = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (cell_match[i] && cell_valid[i]) begin
        found    = 1'b1;
        hit_pos  = SLOT_W'(i);
        hit_slot = cell_slot[i];
      end
    end
  end

  assign full     = (count_q == CNT_W'(MAX_ENTRIES));
  assign fill_now = !found && fill_q;
  assign evict    = fill_now && full;

  always_comb begin
    if (found) begin
      pos        = hit_pos;
      front_slot = hit_slot;
    end else if (full) begin
      pos        = SLOT_W'(MAX_ENTRIES - 1);
      front_slot = cell_slot[MAX_ENTRIES-1];
    end else begin
      pos        = SLOT_W'(count_q);
      front_slot = SLOT_W'(count_q);
    end
  end

  assign count_d = (fill_now && !full) ? count_q + CNT_W'(1) : count_q;

  always_comb begin
    m_data_d        = '0;
    m_data_d[0]     = found;
    m_data_d[1]     = found || fill_q;
    m_data_d[4:2]   = (found || fill_q) ? 3'(front_slot) : 3'd0;
    m_data_d[5]     = evict;
    m_data_d[37:6]  = found ? hits_q + 32'd1 : hits_q;
    m_data_d[69:38] = found ? misses_q : misses_q + 32'd1;
    m_data_d[73:70] = 4'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      hits_q    <= '0;
      misses_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (do_update) begin
        count_q   <= count_d;
        hits_q    <= m_data_d[37:6];
        misses_q  <= m_data_d[69:38];
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q  <= s_axis_tdata[KEY_BITS-1:0];
      fill_q <= s_axis_tuser[0];
    end
    if (do_update) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire
